[rtl/iecho_pkg.sv]
// Shared types, frame offsets and result codes for the ICMP echo responder.
// Depends on nothing; used by iecho_csum and icmp_echo_responder.
package iecho_pkg;

	// Byte offsets inside an Ethernet / IPv4 (20-byte header) / ICMP frame.
	localparam int unsigned MAC_LEN      = 6;
	localparam int unsigned IP_START     = 14;
	localparam int unsigned IP_CK_HI     = 24;
	localparam int unsigned SRC_IP       = 26;
	localparam int unsigned DST_IP       = 30;
	localparam int unsigned ICMP_START   = 34;
	localparam int unsigned ICMP_CK_HI   = 36;
	localparam int unsigned MIN_FRAME    = 38;
	localparam logic [7:0]  ECHO_REQUEST = 8'd8;

	// Result kinds.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_REPLY  = 2'd2;

	// Frame status codes.
	localparam logic [1:0] ST_REPLY    = 2'd0;
	localparam logic [1:0] ST_NOT_ECHO = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_LONG     = 2'd3;

	// Operation codes of a request.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// Where one reply byte comes from.
	typedef enum logic [2:0] {
		SRC_MEM     = 3'd0,
		SRC_IPCK_HI = 3'd1,
		SRC_IPCK_LO = 3'd2,
		SRC_ZERO    = 3'd3,
		SRC_ICCK_HI = 3'd4,
		SRC_ICCK_LO = 3'd5
	} src_t;

	// One stored byte as seen by the checksum accumulators.
	typedef struct packed {
		logic       en;    // byte lands in the store
		logic       clear; // first byte of a new frame
		logic       hdr;   // counts toward the IP header sum
		logic       icmp;  // counts toward the whole ICMP sum
		logic       msg;   // counts toward the ICMP sum for the reply
		logic       odd;   // low byte of a 16-bit word
		logic [7:0] data;
	} csum_req_t;

	// Ones' complement 16-bit add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, v};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

[rtl/iecho_csum.sv]
// Running ones' complement sums kept while a frame is stored.
// Depends on iecho_pkg (csum_req_t, oc_add).
module iecho_csum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iecho_pkg::csum_req_t req,
	output logic [15:0]          header_sum,
	output logic [15:0]          message_sum,
	output logic [15:0]          verify_next
);

	logic [15:0] header_q, message_q, verify_q;
	logic [15:0] header_base, message_base, verify_base;
	logic [15:0] word;
	logic [15:0] header_next, message_next;

	always_comb begin
		header_base  = req.clear ? 16'd0 : header_q;
		message_base = req.clear ? 16'd0 : message_q;
		verify_base  = req.clear ? 16'd0 : verify_q;
		word         = req.odd ? {8'd0, req.data} : {req.data, 8'd0};
		header_next  = req.hdr  ? iecho_pkg::oc_add(header_base, word)  : header_base;
		message_next = req.msg  ? iecho_pkg::oc_add(message_base, word) : message_base;
		verify_next  = req.icmp ? iecho_pkg::oc_add(verify_base, word)  : verify_base;
		if (!req.en) begin
			verify_next = verify_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= 16'd0;
			message_q <= 16'd0;
			verify_q  <= 16'd0;
		end else if (req.en) begin
			header_q  <= header_next;
			message_q <= message_next;
			verify_q  <= verify_next;
		end
	end

	assign header_sum  = header_q;
	assign message_sum = message_q;

endmodule

[rtl/icmp_echo_responder.sv]
// ICMP echo responder top level: frame store, byte counters and the reply read path.
// Depends on iecho_pkg and iecho_csum.
//
// Each request either pushes one received frame byte (operation 0) or pulls
// one reply byte (operation 1). Bytes of a frame are written into an on-chip
// buffer of BUFFER_BYTES bytes while the IP header sum and the two ICMP sums
// accumulate, and only the push that carries last_byte gives a result: the
// frame status. A frame that is an ICMP echo request (type 8 at byte 34) and
// at least 38 bytes long, and that fits the buffer, can then be pulled out as
// an echo reply with swapped MAC and IP addresses, type 0 and both checksums
// recomputed; checksum_bad reports an incoming ICMP checksum that did not
// verify, but the reply is still given. A pull with no reply pending answers
// at once with result kind 0. A pull of a reply byte goes through the
// registered read of the frame buffer and then the output register; the block
// holds off the next request while that read is in flight. The buffer needs
// no clearing pass after reset: the reply only reads bytes of the current
// frame. A push after a finished frame starts a new frame and drops any reply
// not fully pulled.
module icmp_echo_responder #(
	parameter int unsigned BUFFER_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [1:0] frame_status,
	output logic       checksum_bad,
	output logic [7:0] reply_data,
	output logic       reply_last
);

	// Byte counts reach BUFFER_BYTES + 1 (the overflow mark).
	localparam int unsigned CW = $clog2(BUFFER_BYTES + 2);
	localparam int unsigned AW = $clog2(BUFFER_BYTES);

	// Frame buffer: written on pushes, read on reply pulls.
	logic [7:0] frame_mem [BUFFER_BYTES];

	logic [CW-1:0] write_count_q;
	logic [CW-1:0] read_index_q;
	logic          reply_pending_q;
	logic          overflowed_q;
	logic          frame_closed_q;
	logic [7:0]    icmp_type_q;

	// Read stage of a reply pull.
	logic          pull_s1;
	iecho_pkg::src_t src_s1;
	logic          last_s1;
	logic [7:0]    rd_data_s1;

	// Output register.
	logic          out_valid_q;
	logic [1:0]    result_kind_q;
	logic [1:0]    frame_status_q;
	logic          checksum_bad_q;
	logic [7:0]    reply_data_q;
	logic          reply_last_q;

	logic accept, push, pull;
	logic [CW-1:0] wc_base, wc_next, r_next;
	logic          ovf_next, in_range;
	logic [1:0]    status_new;
	logic          bad_new;
	logic [AW-1:0] rd_addr;
	iecho_pkg::src_t rd_src;
	logic [15:0]   header_sum, message_sum, verify_next;
	logic [15:0]   ip_ck, icmp_ck;
	logic [7:0]    reply_byte;
	iecho_pkg::csum_req_t csum_req;

	assign accept = in_valid && in_ready;
	assign push   = accept && (operation == iecho_pkg::OP_PUSH);
	assign pull   = accept && (operation == iecho_pkg::OP_PULL);

	// A new request waits for the read stage and for room in the output register.
	assign in_ready = !pull_s1 && (!out_valid_q || out_ready);

	// Push side: a push after a closed frame starts over from byte zero.
	always_comb begin
		wc_base  = frame_closed_q ? '0 : write_count_q;
		in_range = wc_base < CW'(BUFFER_BYTES);
		wc_next  = in_range ? wc_base + CW'(1) : CW'(BUFFER_BYTES + 1);
		ovf_next = (frame_closed_q ? 1'b0 : overflowed_q) || !in_range;
	end

	always_comb begin
		csum_req.en    = push && in_range;
		csum_req.clear = frame_closed_q;
		csum_req.hdr   = (wc_base >= CW'(iecho_pkg::IP_START))
			&& (wc_base < CW'(iecho_pkg::ICMP_START))
			&& (wc_base != CW'(iecho_pkg::IP_CK_HI))
			&& (wc_base != CW'(iecho_pkg::IP_CK_HI + 1));
		csum_req.icmp  = wc_base >= CW'(iecho_pkg::ICMP_START);
		csum_req.msg   = csum_req.icmp
			&& (wc_base != CW'(iecho_pkg::ICMP_START))
			&& (wc_base != CW'(iecho_pkg::ICMP_CK_HI))
			&& (wc_base != CW'(iecho_pkg::ICMP_CK_HI + 1));
		csum_req.odd   = wc_base[0];
		csum_req.data  = data_byte;
	end

	iecho_csum u_csum (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (csum_req),
		.header_sum  (header_sum),
		.message_sum (message_sum),
		.verify_next (verify_next)
	);

	// Frame verdict on the byte marked last. Overflow wins over a short frame.
	// A frame of 38 bytes or more had its type byte captured on an earlier push.
	always_comb begin
		status_new = iecho_pkg::ST_REPLY;
		bad_new    = 1'b0;
		if (ovf_next) begin
			status_new = iecho_pkg::ST_LONG;
		end else if (wc_next < CW'(iecho_pkg::MIN_FRAME)) begin
			status_new = iecho_pkg::ST_SHORT;
		end else begin
			bad_new    = verify_next != 16'hFFFF;
			status_new = (icmp_type_q == iecho_pkg::ECHO_REQUEST) ?
				iecho_pkg::ST_REPLY : iecho_pkg::ST_NOT_ECHO;
		end
	end

	// Reply byte mapping: swap the MAC pair and the IP pair, patch type and checksums.
	always_comb begin
		rd_src  = iecho_pkg::SRC_MEM;
		rd_addr = read_index_q[AW-1:0];
		if (read_index_q < CW'(iecho_pkg::MAC_LEN)) begin
			rd_addr = AW'(read_index_q + CW'(iecho_pkg::MAC_LEN));
		end else if (read_index_q < CW'(2 * iecho_pkg::MAC_LEN)) begin
			rd_addr = AW'(read_index_q - CW'(iecho_pkg::MAC_LEN));
		end else if (read_index_q >= CW'(iecho_pkg::SRC_IP)
				&& read_index_q < CW'(iecho_pkg::DST_IP)) begin
			rd_addr = AW'(read_index_q + CW'(4));
		end else if (read_index_q >= CW'(iecho_pkg::DST_IP)
				&& read_index_q < CW'(iecho_pkg::ICMP_START)) begin
			rd_addr = AW'(read_index_q - CW'(4));
		end else if (read_index_q == CW'(iecho_pkg::IP_CK_HI)) begin
			rd_src = iecho_pkg::SRC_IPCK_HI;
		end else if (read_index_q == CW'(iecho_pkg::IP_CK_HI + 1)) begin
			rd_src = iecho_pkg::SRC_IPCK_LO;
		end else if (read_index_q == CW'(iecho_pkg::ICMP_START)) begin
			rd_src = iecho_pkg::SRC_ZERO;
		end else if (read_index_q == CW'(iecho_pkg::ICMP_CK_HI)) begin
			rd_src = iecho_pkg::SRC_ICCK_HI;
		end else if (read_index_q == CW'(iecho_pkg::ICMP_CK_HI + 1)) begin
			rd_src = iecho_pkg::SRC_ICCK_LO;
		end
	end

	assign r_next = read_index_q + CW'(1);

	// Frame buffer port: one write on a push within the buffer or one read on a reply pull.
	always_ff @(posedge clk) begin
		if (push && in_range) begin
			frame_mem[wc_base[AW-1:0]] <= data_byte;
		end
		if (pull && reply_pending_q) begin
			rd_data_s1 <= frame_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push && in_range && (wc_base == CW'(iecho_pkg::ICMP_START))) begin
			icmp_type_q <= data_byte;
		end
		if (pull) begin
			src_s1  <= rd_src;
			last_s1 <= r_next >= write_count_q;
		end
	end

	// Frame and reply bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q   <= '0;
			read_index_q    <= '0;
			reply_pending_q <= 1'b0;
			overflowed_q    <= 1'b0;
			frame_closed_q  <= 1'b1;
			pull_s1         <= 1'b0;
		end else begin
			pull_s1 <= pull && reply_pending_q;
			if (push) begin
				write_count_q  <= wc_next;
				overflowed_q   <= ovf_next;
				frame_closed_q <= last_byte;
				if (frame_closed_q) begin
					read_index_q    <= '0;
					reply_pending_q <= 1'b0;
				end
				if (last_byte && (status_new == iecho_pkg::ST_REPLY)) begin
					read_index_q    <= '0;
					reply_pending_q <= 1'b1;
				end
			end else if (pull && reply_pending_q) begin
				read_index_q <= r_next;
				if (r_next >= write_count_q) begin
					reply_pending_q <= 1'b0;
				end
			end
		end
	end

	// Reply byte assembly in the read stage.
	assign ip_ck   = ~header_sum;
	assign icmp_ck = ~message_sum;

	always_comb begin
		unique case (src_s1)
			iecho_pkg::SRC_MEM:     reply_byte = rd_data_s1;
			iecho_pkg::SRC_IPCK_HI: reply_byte = ip_ck[15:8];
			iecho_pkg::SRC_IPCK_LO: reply_byte = ip_ck[7:0];
			iecho_pkg::SRC_ZERO:    reply_byte = 8'd0;
			iecho_pkg::SRC_ICCK_HI: reply_byte = icmp_ck[15:8];
			iecho_pkg::SRC_ICCK_LO: reply_byte = icmp_ck[7:0];
			default:                reply_byte = rd_data_s1;
		endcase
	end

	// Output register: loaded by a closing push, an idle pull or a finished read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((push && last_byte) || (pull && !reply_pending_q) || pull_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && last_byte) begin
			result_kind_q  <= iecho_pkg::KIND_STATUS;
			frame_status_q <= status_new;
			checksum_bad_q <= bad_new;
			reply_data_q   <= 8'd0;
			reply_last_q   <= 1'b0;
		end else if (pull && !reply_pending_q) begin
			result_kind_q  <= iecho_pkg::KIND_NONE;
			frame_status_q <= iecho_pkg::ST_REPLY;
			checksum_bad_q <= 1'b0;
			reply_data_q   <= 8'd0;
			reply_last_q   <= 1'b0;
		end else if (pull_s1) begin
			result_kind_q  <= iecho_pkg::KIND_REPLY;
			frame_status_q <= iecho_pkg::ST_REPLY;
			checksum_bad_q <= 1'b0;
			reply_data_q   <= reply_byte;
			reply_last_q   <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign frame_status = frame_status_q;
	assign checksum_bad = checksum_bad_q;
	assign reply_data   = reply_data_q;
	assign reply_last   = reply_last_q;

	// A buffer read always finds the output register free while it is in flight.
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pull_s1 |-> !out_valid_q)
		else $error("read stage did not find the output register free");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		pull_s1 |=> out_valid_q && (result_kind_q == iecho_pkg::KIND_REPLY))
		else $error("reply byte read did not reach the output");

	// A pending reply never points past the stored frame.
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reply_pending_q |-> (read_index_q < write_count_q)
			&& (write_count_q <= CW'(BUFFER_BYTES)))
		else $error("reply index beyond the stored frame");

	// The overflow mark and the saturated count move together.
	a_overflow_count: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed_q |-> (write_count_q == CW'(BUFFER_BYTES + 1)))
		else $error("overflow flag without saturated byte count");

endmodule
